// ===== hdl/bpc_pkg.sv =====
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types and constants for the push-button press classifier.
// ----------------------------------------------------------------------------
package bpc_pkg;

    localparam int NUM_BUTTONS_DEF = 1;
    localparam int MAX_EVENTS      = 3;
    localparam int FIFO_DEPTH      = 4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_HOLD    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VLONG_HOLD   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_WIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_PIN    = 3'd4;

    // register reset values
    localparam logic [7:0] DEBOUNCE_RST   = 8'd3;
    localparam logic [9:0] LONG_HOLD_RST  = 10'd100;
    localparam logic [9:0] VLONG_HOLD_RST = 10'd300;
    localparam logic [9:0] DOUBLE_WIN_RST = 10'd50;
    localparam logic [2:0] FIRST_PIN_RST  = 3'd4;
    localparam logic [7:0] LEVELS_RST     = 8'hFF;

    // input action codes
    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_EDGE = 1'b1;

    // event codes
    localparam logic [2:0] EV_SHORT           = 3'd0;
    localparam logic [2:0] EV_DOUBLE          = 3'd1;
    localparam logic [2:0] EV_LONG_HOLD       = 3'd2;
    localparam logic [2:0] EV_LONG_PRESS      = 3'd3;
    localparam logic [2:0] EV_VERY_LONG_HOLD  = 3'd4;
    localparam logic [2:0] EV_VERY_LONG_PRESS = 3'd5;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_UNDER_LONG,
        PH_PAST_LONG,
        PH_PAST_VERY_LONG
    } t_hold_phase;

    typedef struct packed {
        logic       action;
        logic [7:0] pins;
    } t_in_item;

    typedef struct packed {
        logic [2:0] button;
        logic [2:0] event_res;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic [1:0]                     count;
        t_out_item [MAX_EVENTS-1:0]     item;
    } t_evt_bundle;

endpackage

// ===== hdl/bpc_core.sv =====
// ----------------------------------------------------------------------------
// bpc_core
// Configuration, debounce and per-button timers; produces up to three events
// for each transaction it is given.
// ----------------------------------------------------------------------------
module bpc_core #(
    parameter int NUM_BUTTONS = bpc_pkg::NUM_BUTTONS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bpc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_go,
    input  bpc_pkg::t_in_item                 i_item,
    output bpc_pkg::t_evt_bundle              o_events
);

    localparam int N_SLOTS = 3 * NUM_BUTTONS;

    logic [7:0] r_deb_ticks;
    logic [9:0] r_long_ticks;
    logic [9:0] r_vlong_ticks;
    logic [9:0] r_dwin_ticks;
    logic [2:0] r_first_pin;

    logic [7:0] r_acc_levels, n_acc_levels;
    logic [7:0] r_edge_sample, n_edge_sample;
    logic [7:0] r_deb_cnt, n_deb_cnt;
    logic       r_deb_run, n_deb_run;

    bpc_pkg::t_hold_phase r_phase [NUM_BUTTONS];
    bpc_pkg::t_hold_phase n_phase [NUM_BUTTONS];
    logic [9:0] r_hold_cnt [NUM_BUTTONS];
    logic [9:0] n_hold_cnt [NUM_BUTTONS];
    logic       r_hold_run [NUM_BUTTONS];
    logic       n_hold_run [NUM_BUTTONS];
    logic       r_dbl_pend [NUM_BUTTONS];
    logic       n_dbl_pend [NUM_BUTTONS];
    logic [9:0] r_dbl_cnt  [NUM_BUTTONS];
    logic [9:0] n_dbl_cnt  [NUM_BUTTONS];
    logic       r_dbl_run  [NUM_BUTTONS];
    logic       n_dbl_run  [NUM_BUTTONS];

    logic [N_SLOTS-1:0] slot_v;
    logic [2:0]         slot_ev  [N_SLOTS];
    logic [2:0]         slot_btn [N_SLOTS];

    logic       deb_fire;
    logic [7:0] changed;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deb_ticks   <= bpc_pkg::DEBOUNCE_RST;
            r_long_ticks  <= bpc_pkg::LONG_HOLD_RST;
            r_vlong_ticks <= bpc_pkg::VLONG_HOLD_RST;
            r_dwin_ticks  <= bpc_pkg::DOUBLE_WIN_RST;
            r_first_pin   <= bpc_pkg::FIRST_PIN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bpc_pkg::CFG_DEBOUNCE:   r_deb_ticks   <= i_cfg_data[7:0];
                bpc_pkg::CFG_LONG_HOLD:  r_long_ticks  <= i_cfg_data[9:0];
                bpc_pkg::CFG_VLONG_HOLD: r_vlong_ticks <= i_cfg_data[9:0];
                bpc_pkg::CFG_DOUBLE_WIN: r_dwin_ticks  <= i_cfg_data[9:0];
                bpc_pkg::CFG_FIRST_PIN:  r_first_pin   <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // debounce path
    always_comb begin
        n_acc_levels  = r_acc_levels;
        n_edge_sample = r_edge_sample;
        n_deb_cnt     = r_deb_cnt;
        n_deb_run     = r_deb_run;
        deb_fire      = 1'b0;
        changed       = '0;
        if (i_go) begin
            if (i_item.action == bpc_pkg::ACT_EDGE) begin
                n_edge_sample = i_item.pins;
                n_deb_cnt     = r_deb_ticks;
                n_deb_run     = 1'b1;
            end else if (r_deb_run) begin
                if (r_deb_cnt <= 8'd1) begin
                    n_deb_run    = 1'b0;
                    n_deb_cnt    = '0;
                    deb_fire     = 1'b1;
                    changed      = (i_item.pins ^ r_acc_levels) &
                                   ~(i_item.pins ^ r_edge_sample);
                    n_acc_levels = i_item.pins;
                end else begin
                    n_deb_cnt = r_deb_cnt - 8'd1;
                end
            end
        end
    end

    // per-button timers and press tracking
    always_comb begin
        logic [3:0] pos;
        logic       tick;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            n_phase[b]    = r_phase[b];
            n_hold_cnt[b] = r_hold_cnt[b];
            n_hold_run[b] = r_hold_run[b];
            n_dbl_pend[b] = r_dbl_pend[b];
            n_dbl_cnt[b]  = r_dbl_cnt[b];
            n_dbl_run[b]  = r_dbl_run[b];
        end
        for (int s = 0; s < N_SLOTS; s++) begin
            slot_v[s]   = 1'b0;
            slot_ev[s]  = bpc_pkg::EV_SHORT;
            slot_btn[s] = '0;
        end
        tick = i_go && (i_item.action == bpc_pkg::ACT_TICK);
        pos  = '0;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            slot_btn[2*b]             = 3'(b);
            slot_btn[2*b+1]           = 3'(b);
            slot_btn[2*NUM_BUTTONS+b] = 3'(b);
            if (tick) begin
                // hold timer
                if (n_hold_run[b]) begin
                    if (n_hold_cnt[b] <= 10'd1) begin
                        n_hold_run[b] = 1'b0;
                        n_hold_cnt[b] = '0;
                        if (n_phase[b] == bpc_pkg::PH_UNDER_LONG) begin
                            slot_v[2*b]   = 1'b1;
                            slot_ev[2*b]  = bpc_pkg::EV_LONG_HOLD;
                            n_hold_cnt[b] = r_vlong_ticks;
                            n_hold_run[b] = 1'b1;
                            n_phase[b]    = bpc_pkg::PH_PAST_LONG;
                        end else if (n_phase[b] == bpc_pkg::PH_PAST_LONG) begin
                            slot_v[2*b]  = 1'b1;
                            slot_ev[2*b] = bpc_pkg::EV_VERY_LONG_HOLD;
                            n_phase[b]   = bpc_pkg::PH_PAST_VERY_LONG;
                        end
                    end else begin
                        n_hold_cnt[b] = n_hold_cnt[b] - 10'd1;
                    end
                end
                // double-press window
                if (n_dbl_run[b]) begin
                    if (n_dbl_cnt[b] <= 10'd1) begin
                        n_dbl_run[b]    = 1'b0;
                        n_dbl_cnt[b]    = '0;
                        n_dbl_pend[b]   = 1'b0;
                        n_phase[b]      = bpc_pkg::PH_IDLE;
                        slot_v[2*b+1]   = 1'b1;
                        slot_ev[2*b+1]  = bpc_pkg::EV_SHORT;
                    end else begin
                        n_dbl_cnt[b] = n_dbl_cnt[b] - 10'd1;
                    end
                end
                // debounced level change
                pos = {1'b0, r_first_pin} + 4'(b);
                if (deb_fire && !pos[3] && changed[pos[2:0]]) begin
                    if (!i_item.pins[pos[2:0]]) begin
                        n_phase[b]    = bpc_pkg::PH_UNDER_LONG;
                        n_hold_cnt[b] = r_long_ticks;
                        n_hold_run[b] = 1'b1;
                    end else begin
                        n_hold_run[b] = 1'b0;
                        n_hold_cnt[b] = '0;
                        unique case (n_phase[b])
                            bpc_pkg::PH_UNDER_LONG: begin
                                if (!n_dbl_pend[b]) begin
                                    n_dbl_pend[b] = 1'b1;
                                    n_dbl_cnt[b]  = r_dwin_ticks;
                                    n_dbl_run[b]  = 1'b1;
                                end else begin
                                    n_dbl_pend[b] = 1'b0;
                                    n_dbl_run[b]  = 1'b0;
                                    n_dbl_cnt[b]  = '0;
                                    slot_v[2*NUM_BUTTONS+b]  = 1'b1;
                                    slot_ev[2*NUM_BUTTONS+b] = bpc_pkg::EV_DOUBLE;
                                end
                            end
                            bpc_pkg::PH_PAST_LONG: begin
                                slot_v[2*NUM_BUTTONS+b]  = 1'b1;
                                slot_ev[2*NUM_BUTTONS+b] = bpc_pkg::EV_LONG_PRESS;
                            end
                            bpc_pkg::PH_PAST_VERY_LONG: begin
                                slot_v[2*NUM_BUTTONS+b]  = 1'b1;
                                slot_ev[2*NUM_BUTTONS+b] = bpc_pkg::EV_VERY_LONG_PRESS;
                            end
                            default: ;
                        endcase
                        n_phase[b] = bpc_pkg::PH_IDLE;
                    end
                end
            end
        end
    end

    // pick the first three events in order
    always_comb begin
        logic [1:0] k;
        k = '0;
        o_events = '0;
        for (int s = 0; s < N_SLOTS; s++) begin
            if (slot_v[s] && (k != 2'd3)) begin
                o_events.item[k].button    = slot_btn[s];
                o_events.item[k].event_res = slot_ev[s];
                k = k + 2'd1;
            end
        end
        for (int j = 0; j < bpc_pkg::MAX_EVENTS; j++) begin
            o_events.item[j].last = (2'(j) + 2'd1 == k);
        end
        o_events.count = k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_levels  <= bpc_pkg::LEVELS_RST;
            r_edge_sample <= bpc_pkg::LEVELS_RST;
            r_deb_cnt     <= '0;
            r_deb_run     <= 1'b0;
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                r_phase[b]    <= bpc_pkg::PH_IDLE;
                r_hold_cnt[b] <= '0;
                r_hold_run[b] <= 1'b0;
                r_dbl_pend[b] <= 1'b0;
                r_dbl_cnt[b]  <= '0;
                r_dbl_run[b]  <= 1'b0;
            end
        end else begin
            r_acc_levels  <= n_acc_levels;
            r_edge_sample <= n_edge_sample;
            r_deb_cnt     <= n_deb_cnt;
            r_deb_run     <= n_deb_run;
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                r_phase[b]    <= n_phase[b];
                r_hold_cnt[b] <= n_hold_cnt[b];
                r_hold_run[b] <= n_hold_run[b];
                r_dbl_pend[b] <= n_dbl_pend[b];
                r_dbl_cnt[b]  <= n_dbl_cnt[b];
                r_dbl_run[b]  <= n_dbl_run[b];
            end
        end
    end

endmodule

// ===== hdl/button_press_classifier.sv =====
// ----------------------------------------------------------------------------
// button_press_classifier
// Debounced active-low push-button classifier: short, double, long and very
// long presses and holds.
// ----------------------------------------------------------------------------
// Each transaction is held in an input register, where it is classified;
// its events (zero to three) go into a four-entry result queue that drains one
// event per cycle while the output is not stalled. An item leaves the input
// register only while the queue holds at most one event. With an empty queue,
// the first event passes through the input register and then the result queue
// before it is offered. The result queue sets the sustained rate.
module button_press_classifier #(
    parameter int NUM_BUTTONS = bpc_pkg::NUM_BUTTONS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bpc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  bpc_pkg::t_in_item                 i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output bpc_pkg::t_out_item                o_out_data
);

    localparam int PTR_W = $clog2(bpc_pkg::FIFO_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    logic              r_in_valid;
    bpc_pkg::t_in_item r_in_item;
    logic              go;
    logic              in_acc;
    logic              out_pop;

    bpc_pkg::t_evt_bundle events;

    bpc_pkg::t_out_item r_fifo [bpc_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   push_n;

    assign go          = r_in_valid && (r_cnt <= CNT_W'(1));
    assign o_in_stall  = r_in_valid && !go;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_cnt != '0);
    assign out_pop     = o_out_valid && !i_out_stall;
    assign o_out_data  = r_fifo[r_rd_ptr];
    assign push_n      = go ? CNT_W'(events.count) : '0;

    bpc_core #(
        .NUM_BUTTONS(NUM_BUTTONS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_go       (go),
        .i_item     (r_in_item),
        .o_events   (events)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_acc) begin
            r_in_valid <= 1'b1;
        end else if (go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_item <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + push_n[PTR_W-1:0];
            if (out_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_cnt <= r_cnt + push_n - (out_pop ? CNT_W'(1) : CNT_W'(0));
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < bpc_pkg::MAX_EVENTS; k++) begin
            if (go && (CNT_W'(k) < push_n)) begin
                r_fifo[r_wr_ptr + PTR_W'(k)] <= events.item[k];
            end
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(bpc_pkg::FIFO_DEPTH))
        else $error("result queue overfilled");

    a_last_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        go && (events.count != 2'd0) |->
            (events.count == 2'd1 && events.item[0].last) ||
            (events.count == 2'd2 && events.item[1].last) ||
            (events.count == 2'd3 && events.item[2].last))
        else $error("final event of a transaction not marked last");

    a_event_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.event_res <= bpc_pkg::EV_VERY_LONG_PRESS)
        else $error("undefined event code on output");

    a_item_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !go |=> r_in_valid && $stable(r_in_item))
        else $error("held input transaction lost");

endmodule
